### src/sbox_pkg.sv
// shared constants and gf(2^8) helper functions for the aes s-box block
package sbox_pkg;

  // low byte of the field polynomial x^8+x^4+x^3+x+1
  localparam logic [7:0] POLY_LOW  = 8'h1B;
  // affine transform constants
  localparam logic [7:0] FWD_CONST = 8'h63;
  localparam logic [7:0] INV_CONST = 8'h05;

  // operation codes
  typedef enum logic {
    OP_FWD = 1'b0,
    OP_INV = 1'b1
  } sbox_op_t;

  // rotate a byte left by a constant amount
  function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
    logic [7:0] r;
    r = (x << n) | (x >> (8 - n));
    return r;
  endfunction

  // field multiply, shift-and-add with reduction
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] acc;
    x   = a;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? POLY_LOW : 8'h00);
    end
    return acc;
  endfunction

  // field square: a linear map, bits spread then reduced
  function automatic logic [7:0] gf_sq(input logic [7:0] a);
    logic [14:0] t;
    t = 15'h0000;
    for (int k = 0; k < 8; k++) begin
      t[2*k] = a[k];
    end
    for (int k = 14; k >= 8; k--) begin
      if (t[k]) begin
        t = t ^ (15'({1'b1, POLY_LOW}) << (k - 8));
      end
    end
    return t[7:0];
  endfunction

  // forward affine transform
  function automatic logic [7:0] affine_fwd(input logic [7:0] x);
    return x ^ rotl8(x, 1) ^ rotl8(x, 2) ^ rotl8(x, 3) ^ rotl8(x, 4) ^ FWD_CONST;
  endfunction

  // inverse affine transform
  function automatic logic [7:0] affine_inv(input logic [7:0] x);
    return rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ INV_CONST;
  endfunction

endpackage

### src/sbox_in_if.sv
// input channel: operation select and byte to substitute
interface sbox_in_if;
  import sbox_pkg::*;

  logic       valid;
  logic       ready;
  sbox_op_t   operation;
  logic [7:0] byte_in;

  modport source (output valid, output operation, output byte_in, input ready);
  modport sink   (input valid, input operation, input byte_in, output ready);
endinterface

### src/sbox_out_if.sv
// result channel: substituted byte
interface sbox_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;

  modport source (output valid, output byte_out, input ready);
  modport sink   (input valid, input byte_out, output ready);
endinterface

### src/aes_sbox_forward_inverse.sv
// aes forward and inverse s-box, four-stage pipeline
//
//   channel  dir  handshake     payload
//   in_if    in   valid/ready   operation (1), byte_in (8)
//   out_if   out  valid/ready   byte_out (8)
//
// one word per cycle sustained while out_if.ready stays high; an accepted word passes through
// the four pipeline registers in order (affine select, power terms, two product levels)
// before out_if.valid rises with its result and the result can be taken
// each stage holds its word while the stage after it is full and stalled; bubbles
// are squeezed out, so in_if.ready stays high while any stage is empty
// synchronous active-low reset clears the valid bits only
module aes_sbox_forward_inverse
  import sbox_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sbox_in_if.sink     in_if,
  sbox_out_if.source  out_if
);

  // stage registers
  logic       v1_r, v2_r, v3_r, v4_r;
  sbox_op_t   op1_r, op2_r, op3_r;
  logic [7:0] x1_r;
  logic [7:0] p6_r, p24_r, p96_r, p128_r;
  logic [7:0] p30_r, p224_r;
  logic [7:0] out_r;

  logic [7:0] x1_nxt;
  logic [7:0] p6_nxt, p24_nxt, p96_nxt, p128_nxt;
  logic [7:0] p30_nxt, p224_nxt;
  logic [7:0] out_nxt;

  logic rdy1, rdy2, rdy3, rdy4;

  // a stage may load when it is empty or its word moves on
  assign rdy4 = !v4_r || out_if.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_if.ready     = rdy1;
  assign out_if.valid    = v4_r;
  assign out_if.byte_out = out_r;

  // stage 1: inverse affine on the inverse path
  assign x1_nxt = (in_if.operation == OP_INV) ? affine_inv(in_if.byte_in) : in_if.byte_in;

  // stage 2: x^6, x^24, x^96 and x^128 from the square chain
  always_comb begin
    logic [7:0] s2, s4, s8, s16, s32, s64;
    s2   = gf_sq(x1_r);
    s4   = gf_sq(s2);
    s8   = gf_sq(s4);
    s16  = gf_sq(s8);
    s32  = gf_sq(s16);
    s64  = gf_sq(s32);
    p6_nxt   = gf_mul(s2, s4);
    p24_nxt  = gf_mul(s8, s16);
    p96_nxt  = gf_mul(s32, s64);
    p128_nxt = gf_sq(s64);
  end

  // stage 3: x^30 and x^224
  assign p30_nxt  = gf_mul(p6_r, p24_r);
  assign p224_nxt = gf_mul(p96_r, p128_r);

  // stage 4: x^254 is the field inverse, then forward affine on the forward path
  always_comb begin
    logic [7:0] inv;
    inv     = gf_mul(p30_r, p224_r);
    out_nxt = (op3_r == OP_FWD) ? affine_fwd(inv) : inv;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_if.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1_r <= in_if.operation;
      x1_r  <= x1_nxt;
    end
    if (rdy2) begin
      op2_r  <= op1_r;
      p6_r   <= p6_nxt;
      p24_r  <= p24_nxt;
      p96_r  <= p96_nxt;
      p128_r <= p128_nxt;
    end
    if (rdy3) begin
      op3_r  <= op2_r;
      p30_r  <= p30_nxt;
      p224_r <= p224_nxt;
    end
    if (rdy4) begin
      out_r <= out_nxt;
    end
  end

endmodule
